[sv/software_timer_task_table_defines.svh]
// Assertion helpers for the timer slot table.
`ifndef SOFTWARE_TIMER_TASK_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TASK_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define STT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("timer table check failed");

// Next-cycle implication, disabled while reset is held.
`define STT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("timer table check failed");

`endif

[sv/stt_pkg.sv]
package stt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SERVICE  = 2'd1,
        OP_REGISTER = 2'd2,
        OP_REMOVE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_REG  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_FULL = 2'd2,
        KIND_DONE = 2'd3
    } kind_t;

    // one slot's stored payload
    typedef struct packed {
        logic [15:0] delay;
        logic [15:0] elapsed;
        logic [7:0]  callback;
    } slot_word_t;

    localparam int WORD_W = $bits(slot_word_t);

    typedef struct packed {
        logic [15:0] elapsed;
        logic        fire;
    } alu_res_t;

    // low 4 bits of a slot number for the result field
    function automatic logic [3:0] slot_field(slot_idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[3:0];
    endfunction

endpackage

[sv/stt_ram.sv]
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/stt_alu.sv]
module stt_alu (
    input  logic [15:0]      elapsed,
    input  logic [15:0]      add,
    input  logic [15:0]      delay,
    output stt_pkg::alu_res_t res
);

    logic [16:0] sum;
    logic [15:0] sat;

    // saturating add, then due check
    assign sum = {1'b0, elapsed} + {1'b0, add};
    assign sat = sum[16] ? 16'hFFFF : sum[15:0];

    assign res.elapsed = sat;
    assign res.fire    = (sat >= delay);

endmodule

[sv/software_timer_task_table.sv]
// Tick and remove finish in IDLE; register scans slots one per cycle, from slot 0 upward.
// Service walks every slot: READ skips a free slot, or issues the RAM read for a used one,
// then UPD updates it through the shared add/compare unit; FIN reports completion.
// Throughput: one request at a time; a waiting result stalls only steps that launch a result.
// Reset (aresetn low, synchronous): all slots freed, pending count cleared, no result out.
`include "software_timer_task_table_defines.svh"

module software_timer_task_table (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic        s_one_shot,
    input  logic [15:0] s_delay_ms,
    input  logic [7:0]  s_callback_id,
    input  logic [3:0]  s_slot_handle,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_slot,
    output logic [7:0]  m_fired_callback,
    output logic        m_last
);

    // Sequencer states:
    //   IDLE  takes a request; tick and remove finish here
    //   SCAN  register: look for the lowest free slot, one per cycle
    //   READ  service: skip free slots, issue RAM read for used ones
    //   UPD   service: add pending time, check due, write back, report fire
    //   FIN   service: report completion and clear pending time
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_READ = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    stt_pkg::slot_idx_t idx_reg, idx_next;
    logic [stt_pkg::SLOTS-1:0] valid_reg, valid_next;
    logic [stt_pkg::SLOTS-1:0] once_reg, once_next;
    logic [15:0] pending_reg, pending_next;

    // latched register request payload
    logic        new_once_reg, new_once_next;
    logic [15:0] new_delay_reg, new_delay_next;
    logic [7:0]  new_cb_reg, new_cb_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    stt_pkg::kind_t m_kind_reg, m_kind_next;
    logic [3:0]    m_slot_reg, m_slot_next;
    logic [7:0]    m_cb_reg, m_cb_next;
    logic          m_last_reg, m_last_next;

    // RAM port signals
    logic                ram_we;
    stt_pkg::slot_word_t ram_wdata;
    logic                ram_re;
    logic [stt_pkg::WORD_W-1:0] ram_rdata_raw;
    stt_pkg::slot_word_t ram_rdata;

    stt_pkg::alu_res_t alu_res;

    // result launch
    logic           produce;
    stt_pkg::kind_t res_kind;
    logic [3:0]     res_slot;
    logic [7:0]     res_cb;
    logic           res_last;

    logic accept;
    logic out_free;
    logic idx_last;
    logic reg_found;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_last  = (idx_reg == stt_pkg::slot_idx_t'(stt_pkg::SLOTS - 1));
    assign reg_found = (state_reg == ST_SCAN) && !valid_reg[idx_reg] && out_free;
    assign ram_rdata = stt_pkg::slot_word_t'(ram_rdata_raw);

    // delay / elapsed / callback per slot; only read for slots marked valid
    stt_ram #(
        .WIDTH(stt_pkg::WORD_W),
        .DEPTH(stt_pkg::SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (idx_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata_raw)
    );

    // the one shared add/compare unit, reused for every slot
    stt_alu u_alu (
        .elapsed (ram_rdata.elapsed),
        .add     (pending_reg),
        .delay   (ram_rdata.delay),
        .res     (alu_res)
    );

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        once_next      = once_reg;
        pending_next   = pending_reg;
        new_once_next  = new_once_reg;
        new_delay_next = new_delay_reg;
        new_cb_next    = new_cb_reg;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        produce        = 1'b0;
        res_kind       = stt_pkg::KIND_DONE;
        res_slot       = 4'd0;
        res_cb         = 8'd0;
        res_last       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (stt_pkg::opcode_t'(s_opcode))
                        stt_pkg::OP_TICK: begin
                            if (pending_reg != 16'hFFFF) begin
                                pending_next = pending_reg + 16'd1;
                            end
                        end
                        stt_pkg::OP_SERVICE: begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                        stt_pkg::OP_REGISTER: begin
                            new_once_next  = s_one_shot;
                            new_delay_next = s_delay_ms;
                            new_cb_next    = s_callback_id;
                            idx_next       = '0;
                            state_next     = ST_SCAN;
                        end
                        stt_pkg::OP_REMOVE: begin
                            // out-of-range handles match nothing
                            for (int i = 0; i < stt_pkg::SLOTS; i++) begin
                                if (32'(s_slot_handle) == i) begin
                                    valid_next[i] = 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!valid_reg[idx_reg]) begin
                    if (out_free) begin
                        ram_we            = 1'b1;
                        ram_wdata.delay   = new_delay_reg;
                        ram_wdata.elapsed = 16'd0;
                        ram_wdata.callback = new_cb_reg;
                        valid_next[idx_reg] = 1'b1;
                        once_next[idx_reg]  = new_once_reg;
                        produce    = 1'b1;
                        res_kind   = stt_pkg::KIND_REG;
                        res_slot   = stt_pkg::slot_field(idx_reg);
                        res_last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (idx_last) begin
                    if (out_free) begin
                        produce    = 1'b1;
                        res_kind   = stt_pkg::KIND_FULL;
                        res_last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + stt_pkg::slot_idx_t'(1);
                end
            end
            ST_READ: begin
                if (valid_reg[idx_reg]) begin
                    ram_re     = 1'b1;
                    state_next = ST_UPD;
                end else if (idx_last) begin
                    state_next = ST_FIN;
                end else begin
                    idx_next = idx_reg + stt_pkg::slot_idx_t'(1);
                end
            end
            ST_UPD: begin
                // a fire needs the output register; otherwise write back at once
                if (!alu_res.fire || out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata.delay    = ram_rdata.delay;
                    ram_wdata.elapsed  = alu_res.fire ? 16'd0 : alu_res.elapsed;
                    ram_wdata.callback = ram_rdata.callback;
                    if (alu_res.fire) begin
                        produce  = 1'b1;
                        res_kind = stt_pkg::KIND_FIRE;
                        res_slot = stt_pkg::slot_field(idx_reg);
                        res_cb   = ram_rdata.callback;
                        if (once_reg[idx_reg]) begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    if (idx_last) begin
                        state_next = ST_FIN;
                    end else begin
                        idx_next   = idx_reg + stt_pkg::slot_idx_t'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    produce      = 1'b1;
                    res_kind     = stt_pkg::KIND_DONE;
                    res_last     = 1'b1;
                    pending_next = 16'd0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: loads a new result, or drains when taken
    always_comb begin
        m_kind_next = m_kind_reg;
        m_slot_next = m_slot_reg;
        m_cb_next   = m_cb_reg;
        m_last_next = m_last_reg;
        if (produce) begin
            m_valid_next = 1'b1;
            m_kind_next  = res_kind;
            m_slot_next  = res_slot;
            m_cb_next    = res_cb;
            m_last_next  = res_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            once_reg    <= '0;
            pending_reg <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            once_reg    <= once_next;
            pending_reg <= pending_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_once_reg  <= new_once_next;
        new_delay_reg <= new_delay_next;
        new_cb_reg    <= new_cb_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_cb_reg      <= m_cb_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_slot           = m_slot_reg;
    assign m_fired_callback = m_cb_reg;
    assign m_last           = m_last_reg;

    // a successful register marks its slot used
    `STT_ASSERT_NEXT(a_reg_sets_valid, aclk, aresetn, reg_found, valid_reg[$past(idx_reg)])

    // table full is only reported with every slot used
    `STT_ASSERT_NOW(a_full_only_when_full, aclk, aresetn,
        produce && (res_kind == stt_pkg::KIND_FULL), &valid_reg)

    // service completion clears the pending time
    `STT_ASSERT_NEXT(a_done_clears_pending, aclk, aresetn,
        produce && (res_kind == stt_pkg::KIND_DONE), pending_reg == 16'd0)

endmodule
